/* hdl/clfa_pkg.sv */
// Shared types and constants for the chunked linear allocator.
// Holds the table sizing, field widths, register and request codes,
// the controller state type and the command/status structs.
package clfa_pkg;

    // Table and address space sizing
    localparam int MAX_CHUNKS = 16;
    localparam int ADDR_BITS  = 40;
    localparam int IDX_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

    // Field widths
    localparam int SIZE_W     = 32;
    localparam int LG_W       = 5;
    localparam int FENCE_W    = 48;
    localparam int OUT_IDX_W  = 4;
    localparam int OUT_ADDR_W = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Aligned offset can reach 2^32, so it carries one extra bit
    localparam int OFF_W      = SIZE_W + 1;

    // Chunk sizes round up to this granule
    localparam int CHUNK_GRAN = 256;

    localparam logic [SIZE_W-1:0] DEFAULT_SIZE_RST = 32'd65536;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_ENABLED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SIZE = 1'd1;

    // Request codes
    localparam logic REQ_ALLOC     = 1'b0;
    localparam logic REQ_END_FRAME = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FIT,
        S_PLACE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic latch;     // capture the accepted word
        logic align;     // align the current chunk's write pointer
        logic fail;      // post a failure result
        logic fit_hit;   // allocate from the current chunk
        logic retire;    // mark current chunk pending, drop it
        logic search;    // look for a free or empty entry
        logic place;     // reuse or create a chunk
        logic eof;       // end-of-frame sweep
        logic load_out;  // move the result to the output register
    } t_cmd;

    typedef struct packed {
        logic is_eof;
        logic enabled;
        logic size_zero;
        logic held;
        logic fits;
    } t_status;

endpackage

/* hdl/clfa_ctrl.sv */
// Controller for the chunked linear allocator: request sequencing and
// output register handshake. Depends on clfa_pkg.
module clfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  clfa_pkg::t_status i_status,
    output clfa_pkg::t_cmd    o_cmd
);
    import clfa_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.is_eof) begin
                    o_cmd.eof = 1'b1;
                    n_state   = S_DONE;
                end else if (!i_status.enabled || i_status.size_zero) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_DONE;
                end else if (i_status.held) begin
                    o_cmd.align = 1'b1;
                    n_state     = S_FIT;
                end else begin
                    o_cmd.search = 1'b1;
                    n_state      = S_PLACE;
                end
            end
            S_FIT: begin
                if (i_status.fits) begin
                    o_cmd.fit_hit = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.retire = 1'b1;
                    o_cmd.search = 1'b1;
                    n_state      = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hdl/clfa_dpath.sv */
// Datapath for the chunked linear allocator: configuration registers,
// chunk table, fit/search/fence logic and result registers.
// Depends on clfa_pkg.
module clfa_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [clfa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [clfa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_req_type,
    input  logic [clfa_pkg::SIZE_W-1:0]         i_alloc_size,
    input  logic [clfa_pkg::LG_W-1:0]           i_align_log2,
    input  logic [clfa_pkg::FENCE_W-1:0]        i_frame_fence,
    input  logic [clfa_pkg::FENCE_W-1:0]        i_completed_fence,
    input  clfa_pkg::t_cmd                      i_cmd,
    output clfa_pkg::t_status                   o_status,
    output logic                                o_ok,
    output logic [clfa_pkg::OUT_IDX_W-1:0]      o_chunk_index,
    output logic [clfa_pkg::SIZE_W-1:0]         o_offset,
    output logic [clfa_pkg::OUT_ADDR_W-1:0]     o_address
);
    import clfa_pkg::*;

    localparam int SUM_W = ADDR_BITS + 2;

    // Configuration
    logic                  r_pool_enabled;
    logic [SIZE_W-1:0]     r_default_size;

    // Latched request
    logic                  r_req_type;
    logic [SIZE_W-1:0]     r_size;
    logic [LG_W-1:0]       r_lg;
    logic [FENCE_W-1:0]    r_ff;
    logic [FENCE_W-1:0]    r_cf;

    // Chunk table
    logic [MAX_CHUNKS-1:0] r_valid;
    logic [MAX_CHUNKS-1:0] r_pending;
    logic [SIZE_W-1:0]     r_esize  [MAX_CHUNKS];
    logic [ADDR_BITS-1:0]  r_ebase  [MAX_CHUNKS];
    logic [SIZE_W-1:0]     r_ewptr  [MAX_CHUNKS];
    logic [FENCE_W-1:0]    r_efence [MAX_CHUNKS];
    logic [IDX_W-1:0]      r_cur;
    logic                  r_held;
    logic [ADDR_BITS:0]    r_next_base;

    // Intermediate results
    logic [OFF_W-1:0]      r_off;
    logic                  r_free_hit, r_empty_hit;
    logic [IDX_W-1:0]      r_free_idx, r_empty_idx;
    logic [SIZE_W:0]       r_rs;

    // Staged result and output register
    logic                  r_res_ok;
    logic [IDX_W-1:0]      r_res_idx;
    logic [SIZE_W-1:0]     r_res_off;
    logic [OUT_ADDR_W-1:0] r_res_addr;
    logic                  r_o_ok;
    logic [IDX_W-1:0]      r_o_idx;
    logic [SIZE_W-1:0]     r_o_off;
    logic [OUT_ADDR_W-1:0] r_o_addr;

    // Combinational signals
    logic [SIZE_W-1:0]     rd_wptr, rd_size;
    logic [ADDR_BITS-1:0]  rd_base;
    logic [IDX_W-1:0]      base_slot;
    logic [SIZE_W-1:0]     align_mask;
    logic [OFF_W-1:0]      n_off;
    logic [OFF_W:0]        fit_end;
    logic                  fits;
    logic [OUT_ADDR_W-1:0] hit_addr;
    logic [MAX_CHUNKS-1:0] is_cur, free_cond, stamp, freeable;
    logic                  free_hit, empty_hit;
    logic [IDX_W-1:0]      free_idx, empty_idx;
    logic [SIZE_W-1:0]     cs;
    logic [SIZE_W:0]       n_rs;
    logic [SUM_W-1:0]      new_end;
    logic                  room, new_ok, place_ok;
    logic [IDX_W-1:0]      place_idx;
    logic [OUT_ADDR_W-1:0] place_addr;

    // Table reads at the current slot; the base read uses the reused slot while placing
    assign base_slot = i_cmd.place ? r_free_idx : r_cur;
    assign rd_wptr   = r_ewptr[r_cur];
    assign rd_size   = r_esize[r_cur];
    assign rd_base   = r_ebase[base_slot];

    // Align the write pointer up to 2^lg
    assign align_mask = (SIZE_W'(1) << r_lg) - SIZE_W'(1);
    assign n_off      = ({1'b0, rd_wptr} + {1'b0, align_mask}) & ~{1'b0, align_mask};

    // Fit check against the current chunk
    assign fit_end  = {1'b0, r_off} + {2'b0, r_size};
    assign fits     = fit_end <= {2'b0, rd_size};
    assign hit_addr = OUT_ADDR_W'((ADDR_BITS + 1)'(rd_base) + (ADDR_BITS + 1)'(r_off));

    // Per-entry conditions for search and end of frame
    always_comb begin
        for (int i = 0; i < MAX_CHUNKS; i++) begin
            is_cur[i]    = r_held && (r_cur == IDX_W'(i));
            free_cond[i] = r_valid[i] && !r_pending[i] && !is_cur[i] &&
                           (r_efence[i] == '0) && (r_esize[i] >= r_size);
            stamp[i]     = r_valid[i] && (r_pending[i] || is_cur[i]);
            freeable[i]  = r_valid[i] && !r_pending[i] && !is_cur[i] &&
                           (r_efence[i] != '0) && (r_efence[i] <= r_cf);
        end
    end

    // Lowest-index pick of a free chunk and of an empty entry
    always_comb begin
        free_hit  = 1'b0;
        free_idx  = '0;
        empty_hit = 1'b0;
        empty_idx = '0;
        for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
            if (free_cond[i]) begin
                free_hit = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                empty_hit = 1'b1;
                empty_idx = IDX_W'(i);
            end
        end
    end

    // New chunk size: max(request, default) rounded up to the granule
    assign cs   = (r_size > r_default_size) ? r_size : r_default_size;
    assign n_rs = ({1'b0, cs} + (SIZE_W + 1)'(CHUNK_GRAN - 1)) &
                  ~(SIZE_W + 1)'(CHUNK_GRAN - 1);

    // New chunk must end at or below the top of the address space
    assign new_end    = SUM_W'(r_next_base) + SUM_W'(r_rs);
    assign room       = new_end <= (SUM_W'(1) << ADDR_BITS);
    assign new_ok     = !r_free_hit && r_empty_hit && !r_rs[SIZE_W] && room;
    assign place_ok   = r_free_hit || new_ok;
    assign place_idx  = r_free_hit ? r_free_idx : r_empty_idx;
    assign place_addr = r_free_hit ? OUT_ADDR_W'(rd_base)
                                   : OUT_ADDR_W'(r_next_base[ADDR_BITS-1:0]);

    // Configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_enabled <= 1'b0;
            r_default_size <= DEFAULT_SIZE_RST;
            r_valid        <= '0;
            r_pending      <= '0;
            r_cur          <= '0;
            r_held         <= 1'b0;
            r_next_base    <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_POOL_ENABLED: r_pool_enabled <= i_cfg_data[0];
                    CFG_DEFAULT_SIZE: r_default_size <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.retire) begin
                r_pending[r_cur] <= 1'b1;
                r_held           <= 1'b0;
            end
            if (i_cmd.place && place_ok) begin
                if (!r_free_hit) begin
                    r_valid[place_idx]   <= 1'b1;
                    r_pending[place_idx] <= 1'b0;
                    r_next_base          <= r_next_base + (ADDR_BITS + 1)'(r_rs);
                end
                r_cur  <= place_idx;
                r_held <= 1'b1;
            end
            if (i_cmd.eof) begin
                r_pending <= '0;
                r_held    <= 1'b0;
            end
        end
    end

    // Chunk table payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.fit_hit) begin
            r_ewptr[r_cur] <= SIZE_W'(fit_end);
        end
        if (i_cmd.place && place_ok) begin
            r_efence[place_idx] <= '0;
            r_ewptr[place_idx]  <= r_size;
            if (!r_free_hit) begin
                r_esize[place_idx] <= r_rs[SIZE_W-1:0];
                r_ebase[place_idx] <= r_next_base[ADDR_BITS-1:0];
            end
        end
        if (i_cmd.eof) begin
            for (int i = 0; i < MAX_CHUNKS; i++) begin
                if (stamp[i]) begin
                    r_efence[i] <= r_ff;
                end else if (freeable[i]) begin
                    r_efence[i] <= '0;
                    r_ewptr[i]  <= '0;
                end
            end
        end
    end

    // Request latch, aligned offset and search results
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req_type <= i_req_type;
            r_size     <= i_alloc_size;
            r_lg       <= i_align_log2;
            r_ff       <= i_frame_fence;
            r_cf       <= i_completed_fence;
        end
        if (i_cmd.align) begin
            r_off <= n_off;
        end
        if (i_cmd.search) begin
            r_free_hit  <= free_hit;
            r_free_idx  <= free_idx;
            r_empty_hit <= empty_hit;
            r_empty_idx <= empty_idx;
            r_rs        <= n_rs;
        end
    end

    // Stage the result word, then move it to the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.fail || i_cmd.eof) begin
            r_res_ok   <= i_cmd.eof;
            r_res_idx  <= '0;
            r_res_off  <= '0;
            r_res_addr <= '0;
        end
        if (i_cmd.fit_hit) begin
            r_res_ok   <= 1'b1;
            r_res_idx  <= r_cur;
            r_res_off  <= r_off[SIZE_W-1:0];
            r_res_addr <= hit_addr;
        end
        if (i_cmd.place) begin
            r_res_ok   <= place_ok;
            r_res_idx  <= place_ok ? place_idx : '0;
            r_res_off  <= '0;
            r_res_addr <= place_ok ? place_addr : '0;
        end
        if (i_cmd.load_out) begin
            r_o_ok   <= r_res_ok;
            r_o_idx  <= r_res_idx;
            r_o_off  <= r_res_off;
            r_o_addr <= r_res_addr;
        end
    end

    assign o_status.is_eof    = (r_req_type == REQ_END_FRAME);
    assign o_status.enabled   = r_pool_enabled;
    assign o_status.size_zero = (r_size == '0);
    assign o_status.held      = r_held;
    assign o_status.fits      = fits;

    assign o_ok          = r_o_ok;
    assign o_chunk_index = OUT_IDX_W'(r_o_idx);
    assign o_offset      = r_o_off;
    assign o_address     = r_o_addr;

endmodule

/* hdl/chunked_linear_allocator_with_fences.sv */
// Top level of the chunked linear allocator with fences.
// Joins clfa_ctrl and clfa_dpath; depends on clfa_pkg.
//
//  channel   direction  handshake                  words carried
//  request   in         i_in_valid / o_in_ready    req_type, alloc_size, align_log2,
//                                                  frame_fence, completed_fence
//  result    out        o_out_valid / i_out_ready  ok, chunk_index, offset, address
//  config    in         i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
// Steps per word: end of frame or an early failure goes from decode straight to the
// result; an allocation that fits the current chunk takes the align add, then the fit
// compare; one made with no chunk current takes the search, then placement; when the
// current chunk misses, the table is then searched (16-way parallel size/fence compare,
// then placement with the address-space check). Only one word is in flight at a time.
// Reset is synchronous and active low; it clears valid and pending bits at once.
// A stalled result holds in the output register; the next request is accepted
// meanwhile and waits for it before its own result is posted. Config is always ready.
module chunked_linear_allocator_with_fences (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_req_type,
    input  logic [clfa_pkg::SIZE_W-1:0]         i_alloc_size,
    input  logic [clfa_pkg::LG_W-1:0]           i_align_log2,
    input  logic [clfa_pkg::FENCE_W-1:0]        i_frame_fence,
    input  logic [clfa_pkg::FENCE_W-1:0]        i_completed_fence,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_ok,
    output logic [clfa_pkg::OUT_IDX_W-1:0]      o_chunk_index,
    output logic [clfa_pkg::SIZE_W-1:0]         o_offset,
    output logic [clfa_pkg::OUT_ADDR_W-1:0]     o_address,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [clfa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [clfa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import clfa_pkg::*;

    t_cmd    cmd;
    t_status st;

    assign o_cfg_ready = 1'b1;

    clfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (st),
        .o_cmd       (cmd)
    );

    clfa_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req_type),
        .i_alloc_size      (i_alloc_size),
        .i_align_log2      (i_align_log2),
        .i_frame_fence     (i_frame_fence),
        .i_completed_fence (i_completed_fence),
        .i_cmd             (cmd),
        .o_status          (st),
        .o_ok              (o_ok),
        .o_chunk_index     (o_chunk_index),
        .o_offset          (o_offset),
        .o_address         (o_address)
    );

    // A failed allocation carries an all-zero payload
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |->
            (o_chunk_index == '0 && o_offset == '0 && o_address == '0))
        else $error("failure result with nonzero payload");

    // Only one word in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    // Allocating from the current chunk keeps it current
    a_hit_keeps_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fit_hit |=> st.held)
        else $error("current chunk lost after a fitting allocation");

    // End of frame leaves no chunk current
    a_eof_drops_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.eof |=> !st.held)
        else $error("chunk still current after end of frame");

endmodule
